// ----- rtl/core/pvp_pkg.sv -----
package pvp_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;
  localparam int FRAC_BITS  = 16;
  localparam int COEF_SHIFT = 15;
  localparam int CHUNK_W    = 16;

  localparam logic [15:0] COEF_ONE = 16'h8000;

  localparam logic [CFG_IDX_W-1:0] CFG_KP       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KI_DT    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_KD_DT    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FF       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_D_COEF   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_OUT_MIN  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_OUT_MAX  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_INT_BNDS = 3'd7;

  localparam logic [CFG_DATA_W-1:0] INT_BNDS_RST = 64'h7FFF_FFFF_8000_0000;

  typedef enum logic [1:0] {
    OP_VEL = 2'd0,
    OP_POS = 2'd1,
    OP_CLR = 2'd2,
    OP_NOP = 2'd3
  } opcode_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_MUL,
    ST_POS,
    ST_FIN
  } state_t;

  // one product each
  typedef enum logic [2:0] {
    TM_FILT_A,
    TM_FILT_B,
    TM_KP_DE,
    TM_KI_E,
    TM_KD_D,
    TM_FF,
    TM_KP_E
  } term_t;

endpackage

// ----- rtl/core/pvp_if.sv -----
interface pvp_in_if #(parameter int DATA_WIDTH = 32) ();
  logic                         valid;
  logic                         ready;
  logic [1:0]                   opcode;
  logic signed [DATA_WIDTH-1:0] setpoint;
  logic signed [DATA_WIDTH-1:0] measured;
  logic signed [DATA_WIDTH-1:0] feedforward;

  modport source (output valid, opcode, setpoint, measured, feedforward, input ready);
  modport sink (input valid, opcode, setpoint, measured, feedforward, output ready);
endinterface

interface pvp_out_if #(parameter int DATA_WIDTH = 32) ();
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] control_out;

  modport source (output valid, control_out, input ready);
  modport sink (input valid, control_out, output ready);
endinterface

// ----- rtl/core/pvp_mac.sv -----
module pvp_mac #(
  parameter int A_W = 33,
  parameter int B_W = 32
) (
  input  logic                                                 clk,
  input  logic                                                 rst,
  input  logic                                                 start,
  input  logic signed [A_W-1:0]                                a,
  input  logic signed [B_W-1:0]                                b,
  output logic signed [A_W+pvp_pkg::CHUNK_W*((B_W+pvp_pkg::CHUNK_W-1)/pvp_pkg::CHUNK_W)+1:0] prod,
  output logic                                                 done
);
  import pvp_pkg::*;

  localparam int NC = (B_W + CHUNK_W - 1) / CHUNK_W;
  localparam int XB = NC * CHUNK_W;
  localparam int PW = A_W + XB + 2;
  localparam int CW = (NC > 1) ? $clog2(NC) : 1;

  logic signed [A_W-1:0]       a_r;
  logic [XB-1:0]               b_r;
  logic [XB:0]                 bx;
  logic [CW-1:0]               rem;
  logic                        busy;
  logic signed [A_W-1:0]       ma;
  logic signed [CHUNK_W:0]     mb;
  logic signed [A_W+CHUNK_W:0] mult;
  logic signed [PW-1:0]        mult_x;
  logic signed [PW-1:0]        acc;

  // top chunk of b is signed, the rest go in unsigned, high to low
  assign bx     = {{(XB-B_W+1){b[B_W-1]}}, b};
  assign ma     = start ? a : a_r;
  assign mb     = start ? {bx[XB-1], bx[XB-1 -: CHUNK_W]} : {1'b0, b_r[XB-1 -: CHUNK_W]};
  assign mult   = ma * mb;
  assign mult_x = {{(PW-A_W-CHUNK_W-1){mult[A_W+CHUNK_W]}}, mult};
  assign done   = busy && (rem == '0);
  assign prod   = acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      rem  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      rem  <= CW'(NC - 1);
    end else if (busy) begin
      if (rem != '0) begin
        rem <= rem - 1'b1;
      end else begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r <= a;
      b_r <= bx[XB-1:0] << CHUNK_W;
      acc <= mult_x;
    end else if (busy && rem != '0) begin
      b_r <= b_r << CHUNK_W;
      acc <= (acc <<< CHUNK_W) + mult_x;
    end
  end

endmodule

// ----- rtl/core/pid_velocity_positional.sv -----
// Velocity and positional items run each product through the single (DATA_WIDTH+1) x 17
// multiplier in turn, with NC = ceil(DATA_WIDTH/16) chunks per product; clear and unused
// opcodes go straight to the result. The next item is taken only once the result is
// loaded.
// A waiting result does not block the next accept.
// Synchronous active-high reset: registers to defaults, history and held output to zero, output valid cleared.
module pid_velocity_positional #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [pvp_pkg::CFG_IDX_W-1:0]     cfg_idx,
  input  logic [pvp_pkg::CFG_DATA_W-1:0]    cfg_data,
  pvp_in_if.sink                            in_ch,
  pvp_out_if.source                         out_ch
);
  import pvp_pkg::*;

  localparam int W   = DATA_WIDTH;
  localparam int A_W = W + 1;
  localparam int NC  = (W + CHUNK_W - 1) / CHUNK_W;
  localparam int PW  = A_W + NC * CHUNK_W + 2;
  localparam int AW  = ((W > 32) ? W : 32) + 4;
  localparam int FSW = W + 17;

  localparam logic signed [W-1:0]  W_MAX = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0]  W_MIN = {1'b1, {(W-1){1'b0}}};
  localparam logic signed [AW-1:0] A_MAX = {{(AW-W+1){1'b0}}, {(W-1){1'b1}}};
  localparam logic signed [AW-1:0] A_MIN = {{(AW-W+1){1'b1}}, {(W-1){1'b0}}};
  localparam logic signed [PW-1:0] P_MAX = {{(PW-W+1){1'b0}}, {(W-1){1'b1}}};
  localparam logic signed [PW-1:0] P_MIN = {{(PW-W+1){1'b1}}, {(W-1){1'b0}}};

  function automatic logic signed [W-1:0] sat_a(input logic signed [AW-1:0] x);
    logic signed [W-1:0] r;
    if (x > A_MAX) r = W_MAX;
    else if (x < A_MIN) r = W_MIN;
    else r = x[W-1:0];
    return r;
  endfunction

  function automatic logic signed [W-1:0] sat_p(input logic signed [PW-1:0] x);
    logic signed [W-1:0] r;
    if (x > P_MAX) r = W_MAX;
    else if (x < P_MIN) r = W_MIN;
    else r = x[W-1:0];
    return r;
  endfunction

  function automatic logic signed [AW-1:0] ext_a(input logic signed [W-1:0] x);
    return {{(AW-W){x[W-1]}}, x};
  endfunction

  // configuration
  logic signed [W-1:0] kp, ki, kd, ffg, omin, omax;
  logic [15:0]         dcoef;
  logic [63:0]         ibnds;

  // controller state
  logic signed [W-1:0] e1, e2, integ, dfilt, ohold;

  // per-item work registers
  state_t              state, state_next;
  term_t               term, term_nx, sel_term, term_first;
  opcode_t             op_r, op_in;
  logic signed [W-1:0] e_r, ffi_r, p_r, f_r;
  logic [15:0]         c_r, c_in;
  logic signed [FSW-1:0] fsum, dsum;
  logic signed [AW-1:0]  tsum;
  logic                hold_r;
  logic                out_valid;
  logic signed [W-1:0] out_data;

  logic                in_fire, fin_go, last, mac_start, mac_done;
  logic signed [A_W-1:0] mac_a;
  logic signed [W-1:0]   mac_b;
  logic signed [PW-1:0]  prod, pshift;
  logic signed [W-1:0]   t, e_in, raw, de, dnew, isat, inew, rsat, rclamp, res;
  logic signed [AW-1:0]  pre, ix, imax_x, imin_x;
  logic                  hi, lo;

  assign in_ch.ready    = (state == ST_IDLE);
  assign in_fire        = in_ch.valid && in_ch.ready;
  assign out_ch.valid   = out_valid;
  assign out_ch.control_out = out_data;

  assign op_in      = opcode_t'(in_ch.opcode);
  assign term_first = (op_in == OP_POS) ? TM_KP_E : TM_FILT_A;
  assign c_in       = (dcoef > COEF_ONE) ? COEF_ONE : dcoef;
  assign e_in       = sat_a(ext_a(in_ch.setpoint) - ext_a(in_ch.measured));

  assign raw = sat_a(ext_a(e_r) - (ext_a(e1) <<< 1) + ext_a(e2));
  assign de  = sat_a(ext_a(e_r) - ext_a(e1));

  assign pshift = prod >>> FRAC_BITS;
  assign t      = sat_p(pshift);

  // filter: floor((c*df + (1-c)*raw) / 2^15)
  assign dsum = fsum + $signed(prod[FSW-1:0]);
  assign dnew = W'(dsum >>> COEF_SHIFT);

  assign last = ((op_r == OP_VEL) && (term == TM_FF)) ||
                ((op_r == OP_POS) && (term == TM_KI_E));

  always_comb begin
    case (term)
      TM_FILT_A: term_nx = TM_FILT_B;
      TM_FILT_B: term_nx = TM_KP_DE;
      TM_KP_DE:  term_nx = TM_KI_E;
      TM_KI_E:   term_nx = TM_KD_D;
      TM_KD_D:   term_nx = TM_FF;
      TM_FF:     term_nx = TM_KI_E;
      TM_KP_E:   term_nx = TM_FF;
      default:   term_nx = TM_FILT_A;
    endcase
  end

  assign mac_start = (state == ST_LOAD) || ((state == ST_MUL) && mac_done && !last);
  assign sel_term  = (state == ST_LOAD) ? term : term_nx;

  always_comb begin
    case (sel_term)
      TM_FILT_A: begin
        mac_a = {{(W-15){1'b0}}, c_r};
        mac_b = dfilt;
      end
      TM_FILT_B: begin
        mac_a = {{(W-15){1'b0}}, COEF_ONE - c_r};
        mac_b = raw;
      end
      TM_KP_DE: begin
        mac_a = {kp[W-1], kp};
        mac_b = de;
      end
      TM_KI_E: begin
        mac_a = {ki[W-1], ki};
        mac_b = e_r;
      end
      TM_KD_D: begin
        mac_a = {kd[W-1], kd};
        mac_b = dfilt;
      end
      TM_FF: begin
        mac_a = {ffg[W-1], ffg};
        mac_b = ffi_r;
      end
      TM_KP_E: begin
        mac_a = {kp[W-1], kp};
        mac_b = e_r;
      end
      default: begin
        mac_a = '0;
        mac_b = '0;
      end
    endcase
  end

  pvp_mac #(
    .A_W (A_W),
    .B_W (W)
  ) u_mac (
    .clk   (clk),
    .rst   (rst),
    .start (mac_start),
    .a     (mac_a),
    .b     (mac_b),
    .prod  (prod),
    .done  (mac_done)
  );

  // positional: hold the integrator while the output is pushed into a clamp
  assign pre = ext_a(p_r) + ext_a(integ) + ext_a(t);
  assign hi  = (pre >= ext_a(omax)) && !e_r[W-1] && (e_r != '0);
  assign lo  = (pre <= ext_a(omin)) && e_r[W-1];

  assign imax_x = {{(AW-32){ibnds[63]}}, ibnds[63:32]};
  assign imin_x = {{(AW-32){ibnds[31]}}, ibnds[31:0]};
  assign isat   = sat_a(ext_a(integ) + ext_a(t));

  always_comb begin
    ix = ext_a(isat);
    if (ix > imax_x) ix = imax_x;
    if (ix < imin_x) ix = imin_x;
    inew = sat_a(ix);
  end

  // upper clamp first, so crossed limits give the minimum
  always_comb begin
    rsat   = sat_a(tsum);
    rclamp = rsat;
    if (rclamp > omax) rclamp = omax;
    if (rclamp < omin) rclamp = omin;
    res = ((op_r == OP_VEL) || (op_r == OP_POS)) ? rclamp : ohold;
  end

  assign fin_go = (state == ST_FIN) && (!out_valid || out_ch.ready);

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_fire) begin
          state_next = ((op_in == OP_VEL) || (op_in == OP_POS)) ? ST_LOAD : ST_FIN;
        end
      end
      ST_LOAD: state_next = ST_MUL;
      ST_MUL: begin
        if (mac_done && last) begin
          state_next = (op_r == OP_POS) ? ST_POS : ST_FIN;
        end
      end
      ST_POS: state_next = ST_FIN;
      ST_FIN: begin
        if (fin_go) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      term      <= TM_FILT_A;
      out_valid <= 1'b0;
      kp        <= '0;
      ki        <= '0;
      kd        <= '0;
      ffg       <= '0;
      dcoef     <= '0;
      omin      <= W_MIN;
      omax      <= W_MAX;
      ibnds     <= INT_BNDS_RST;
      e1        <= '0;
      e2        <= '0;
      integ     <= '0;
      dfilt     <= '0;
      ohold     <= '0;
    end else begin
      state <= state_next;

      if (in_fire) begin
        term <= term_first;
      end else if (mac_start) begin
        term <= sel_term;
      end

      if (cfg_we) begin
        case (cfg_idx)
          CFG_KP:       kp    <= cfg_data[W-1:0];
          CFG_KI_DT:    ki    <= cfg_data[W-1:0];
          CFG_KD_DT:    kd    <= cfg_data[W-1:0];
          CFG_FF:       ffg   <= cfg_data[W-1:0];
          CFG_D_COEF:   dcoef <= cfg_data[15:0];
          CFG_OUT_MIN:  omin  <= cfg_data[W-1:0];
          CFG_OUT_MAX:  omax  <= cfg_data[W-1:0];
          CFG_INT_BNDS: ibnds <= cfg_data;
          default: ;
        endcase
      end

      if ((state == ST_MUL) && mac_done) begin
        if (term == TM_FILT_B) dfilt <= dnew;
        if ((term == TM_KI_E) && (op_r == OP_POS) && !hold_r) integ <= inew;
      end

      if (fin_go) begin
        out_valid <= 1'b1;
        ohold     <= res;
        case (op_r)
          OP_VEL: begin
            e2 <= e1;
            e1 <= e_r;
          end
          OP_POS: e1 <= e_r;
          OP_CLR: begin
            e1    <= '0;
            e2    <= '0;
            integ <= '0;
            dfilt <= '0;
          end
          default: ;
        endcase
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_r  <= op_in;
      e_r   <= e_in;
      ffi_r <= in_ch.feedforward;
      c_r   <= c_in;
    end

    if ((state == ST_MUL) && mac_done) begin
      case (term)
        TM_FILT_A: fsum <= $signed(prod[FSW-1:0]);
        TM_KP_DE:  tsum <= ext_a(ohold) + ext_a(t);
        TM_KI_E: begin
          if (op_r == OP_VEL) tsum <= tsum + ext_a(t);
        end
        TM_KD_D:   tsum <= tsum + ext_a(t);
        TM_FF: begin
          if (op_r == OP_VEL) begin
            tsum <= tsum + ext_a(t);
          end else begin
            f_r    <= t;
            hold_r <= hi || lo;
          end
        end
        TM_KP_E:   p_r <= t;
        default: ;
      endcase
    end

    if (state == ST_POS) begin
      tsum <= ext_a(p_r) + ext_a(integ) + ext_a(f_r);
    end

    if (fin_go) begin
      out_data <= res;
    end
  end

endmodule

// ----- rtl/core/pvp_chk.sv -----
module pvp_chk #(
  parameter int W = 32
) (
  input logic         clk,
  input logic         rst,
  input logic         in_valid,
  input logic         in_ready,
  input logic         out_valid,
  input logic         out_ready,
  input logic [W-1:0] out_data
);

  logic       in_fire, out_fire;
  logic [1:0] pend;

  assign in_fire  = in_valid && in_ready;
  assign out_fire = out_valid && out_ready;

  // items taken but not yet delivered
  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 2'd0;
    end else if (in_fire && !out_fire) begin
      pend <= pend + 2'd1;
    end else if (out_fire && !in_fire) begin
      pend <= pend - 2'd1;
    end
  end

  a_reset_state: assert property (@(posedge clk)
    rst |=> !out_valid && in_ready)
    else $error("not idle after reset");

  a_idle_pending: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> (pend == {1'b0, out_valid}))
    else $error("ready with an item still in flight");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> !in_ready)
    else $error("ready right after an accept");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

endmodule

bind pid_velocity_positional pvp_chk #(.W(DATA_WIDTH)) u_pvp_chk (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_data  (out_ch.control_out)
);

// ----- verif/tb_pid_velocity_positional.sv -----
module tb_pid_velocity_positional;
  import pvp_pkg::*;

  localparam int DATA_W        = 32;
  localparam int SETTLE_CYCLES = 16;
  localparam int STALL_LIMIT   = 2000;
  localparam int PHASES        = 13;
  localparam int PHASE_ITEMS   = 100;
  localparam int MAX_PRINTS    = 100;

  localparam logic [31:0] Q_ONE = 32'h0001_0000;
  localparam logic [31:0] W_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] W_MIN = 32'h8000_0000;

  localparam longint SAT_HI = 64'sd2147483647;
  localparam longint SAT_LO = -64'sd2147483648;

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  pvp_in_if  #(.DATA_WIDTH(DATA_W)) in_ch ();
  pvp_out_if #(.DATA_WIDTH(DATA_W)) out_ch ();

  pid_velocity_positional #(.DATA_WIDTH(DATA_W)) i_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data),
    .in_ch    (in_ch),
    .out_ch   (out_ch)
  );

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  // controller image: registers and history
  longint      pid_kp, pid_ki_dt, pid_kd_dt, pid_ff, pid_out_min, pid_out_max;
  logic [15:0] pid_d_coef;
  logic [63:0] pid_int_bounds;
  longint      pid_err1, pid_err2, pid_integ, pid_dfilt, pid_hold;

  logic [31:0] expected_drive[$];
  int          err_count;
  int          idle_cycles;
  int          rdy_left;
  bit          calm;

  function automatic longint q_val(logic [31:0] w);
    return longint'($signed(w));
  endfunction

  function automatic longint sat_w(longint x);
    if (x > SAT_HI) return SAT_HI;
    if (x < SAT_LO) return SAT_LO;
    return x;
  endfunction

  // Q16.16 product, floor of the low bits, then saturate
  function automatic longint q16_mul(longint a, longint b);
    longint prod;
    prod = a * b;
    return sat_w(prod >>> FRAC_BITS);
  endfunction

  // upper clamp first, so crossed limits give the lower one
  function automatic longint clamp_drive(longint x);
    if (x > pid_out_max) x = pid_out_max;
    if (x < pid_out_min) x = pid_out_min;
    return x;
  endfunction

  function automatic void reset_image();
    pid_kp         = 0;
    pid_ki_dt      = 0;
    pid_kd_dt      = 0;
    pid_ff         = 0;
    pid_d_coef     = '0;
    pid_out_min    = SAT_LO;
    pid_out_max    = SAT_HI;
    pid_int_bounds = INT_BNDS_RST;
    pid_err1       = 0;
    pid_err2       = 0;
    pid_integ      = 0;
    pid_dfilt      = 0;
    pid_hold       = 0;
  endfunction

  function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    case (idx)
      CFG_KP:       pid_kp = q_val(data[31:0]);
      CFG_KI_DT:    pid_ki_dt = q_val(data[31:0]);
      CFG_KD_DT:    pid_kd_dt = q_val(data[31:0]);
      CFG_FF:       pid_ff = q_val(data[31:0]);
      CFG_D_COEF:   pid_d_coef = data[15:0];
      CFG_OUT_MIN:  pid_out_min = q_val(data[31:0]);
      CFG_OUT_MAX:  pid_out_max = q_val(data[31:0]);
      CFG_INT_BNDS: pid_int_bounds = data;
      default: ;
    endcase
  endfunction

  function automatic logic [31:0] predict_drive(opcode_t op, logic [31:0] sp, logic [31:0] ms,
                                                logic [31:0] ff);
    longint e, c, raw, dp, di, dd, dff, p, f, pre, acc, imax, imin;
    bit     hi, lo;
    e = sat_w(q_val(sp) - q_val(ms));
    case (op)
      OP_VEL: begin
        c = (pid_d_coef > COEF_ONE) ? longint'(COEF_ONE) : longint'(pid_d_coef);
        raw = sat_w(e - 2 * pid_err1 + pid_err2);
        pid_dfilt = (c * pid_dfilt + (longint'(COEF_ONE) - c) * raw) >>> COEF_SHIFT;
        dp = q16_mul(pid_kp, sat_w(e - pid_err1));
        di = q16_mul(pid_ki_dt, e);
        dd = q16_mul(pid_kd_dt, pid_dfilt);
        dff = q16_mul(pid_ff, q_val(ff));
        pid_hold = clamp_drive(sat_w(pid_hold + dp + di + dd + dff));
        pid_err2 = pid_err1;
        pid_err1 = e;
      end
      OP_POS: begin
        imax = q_val(pid_int_bounds[63:32]);
        imin = q_val(pid_int_bounds[31:0]);
        p = q16_mul(pid_kp, e);
        f = q16_mul(pid_ff, q_val(ff));
        pre = p + pid_integ + f;
        hi = (pre >= pid_out_max) && (e > 0);
        lo = (pre <= pid_out_min) && (e < 0);
        // conditional integration: hold the integrator while pushing into a clamp
        if (!hi && !lo) begin
          acc = sat_w(pid_integ + q16_mul(pid_ki_dt, e));
          if (acc > imax) acc = imax;
          if (acc < imin) acc = imin;
          pid_integ = acc;
        end
        pid_hold = clamp_drive(sat_w(p + pid_integ + f));
        pid_err1 = e;
      end
      OP_CLR: begin
        pid_err1 = 0;
        pid_err2 = 0;
        pid_integ = 0;
        pid_dfilt = 0;
      end
      default: ;
    endcase
    return pid_hold[31:0];
  endfunction

  function automatic int pick_gap();
    if ($urandom_range(0, 9) == 0) return $urandom_range(10, 40);
    return $urandom_range(1, 3);
  endfunction

  task automatic report_mismatch(string what, logic [31:0] want, logic [31:0] got);
    err_count++;
    if (err_count <= MAX_PRINTS)
      $display("mismatch %0d: %s: expected %h, got %h (t=%0t)", err_count, what, want, got,
               $realtime);
  endtask

  // receiver: random back-pressure, none while calm
  always @(posedge clk) begin
    if (calm) begin
      out_ch.ready <= 1'b1;
    end else if (rdy_left == 0) begin
      if ($urandom_range(0, 2) == 0) begin
        out_ch.ready <= 1'b0;
        rdy_left <= pick_gap();
      end else begin
        out_ch.ready <= 1'b1;
        rdy_left <= $urandom_range(1, 12);
      end
    end else begin
      rdy_left <= rdy_left - 1;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (expected_drive.size() == 0) begin
        report_mismatch("control_out with no item pending", 'x, out_ch.control_out);
      end else begin
        logic [31:0] want;
        want = expected_drive.pop_front();
        if (out_ch.control_out !== want)
          report_mismatch("control_out", want, out_ch.control_out);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || cfg_we)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("timeout: no handshake for %0d cycles", STALL_LIMIT);
      $display("pid_velocity_positional regression: fail");
      $finish;
    end
  end

  task automatic push_item(opcode_t op, logic [31:0] sp, logic [31:0] ms, logic [31:0] ff);
    int gap;
    gap = (calm || $urandom_range(0, 1) == 0) ? 0 : pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.opcode      <= op;
    in_ch.setpoint    <= sp;
    in_ch.measured    <= ms;
    in_ch.feedforward <= ff;
    do @(posedge clk); while (!in_ch.ready);
    expected_drive.push_back(predict_drive(op, sp, ms, ff));
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    while (expected_drive.size() != 0) @(posedge clk);
  endtask

  task automatic settle();
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk);
    apply_reg(idx, data);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 9))
      0:       return W_MAX;
      1:       return W_MIN;
      2, 3:    return $urandom;
      default: return $urandom_range(0, 32'h00C8_0000) - 32'h0064_0000;
    endcase
  endfunction

  function automatic logic [31:0] rand_gain();
    case ($urandom_range(0, 9))
      0:       return W_MAX;
      1:       return W_MIN;
      2:       return '0;
      3:       return $urandom;
      default: return $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
    endcase
  endfunction

  function automatic logic [15:0] rand_coef();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return COEF_ONE;
      2:       return 16'($urandom_range(32769, 65535));
      default: return 16'($urandom_range(0, 32768));
    endcase
  endfunction

  function automatic void rand_limits(output logic [31:0] lo, output logic [31:0] hi);
    logic [31:0] mag;
    mag = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 32'h7FFF_FFFF)
                                      : $urandom_range(0, 32'h03E8_0000);
    case ($urandom_range(0, 7))
      0: begin
        lo = W_MIN;
        hi = W_MAX;
      end
      1: begin
        lo = mag;
        hi = -mag;
      end
      default: begin
        lo = -mag;
        hi = mag;
      end
    endcase
  endfunction

  function automatic opcode_t rand_opcode();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return OP_VEL;
    if (r < 85) return OP_POS;
    if (r < 95) return OP_CLR;
    return OP_NOP;
  endfunction

  // defaults after reset, then unit gains against full-scale inputs
  task automatic test_reset_defaults();
    push_item(OP_VEL, W_MAX, W_MIN, W_MAX);
    push_item(OP_NOP, '0, '0, '0);
    push_item(OP_POS, Q_ONE, '0, Q_ONE);
    settle();
    write_reg(CFG_KP, Q_ONE);
    write_reg(CFG_KI_DT, Q_ONE);
    write_reg(CFG_KD_DT, Q_ONE);
    write_reg(CFG_FF, Q_ONE);
    push_item(OP_POS, W_MAX, W_MIN, W_MAX);
    push_item(OP_POS, W_MIN, W_MAX, W_MIN);
    push_item(OP_VEL, W_MAX, W_MIN, W_MAX);
    push_item(OP_VEL, '0, '0, '0);
    push_item(OP_CLR, W_MAX, W_MAX, W_MAX);
    push_item(OP_VEL, W_MIN, W_MAX, W_MIN);
    push_item(OP_NOP, W_MIN, W_MIN, W_MIN);
  endtask

  task automatic test_special_cases();
    // coefficient above one, crossed output clamps, crossed integrator limits
    settle();
    write_reg(CFG_D_COEF, 16'hFFFF);
    write_reg(CFG_OUT_MIN, 32'h0001_0000);
    write_reg(CFG_OUT_MAX, 32'hFFFF_0000);
    write_reg(CFG_INT_BNDS, 64'hFFFF_0000_0001_0000);
    push_item(OP_VEL, 32'h0003_0000, '0, '0);
    push_item(OP_VEL, '0, Q_ONE, '0);
    push_item(OP_POS, Q_ONE, '0, '0);
    // ordered limits; positional steps in between leave pid_err2 alone
    settle();
    write_reg(CFG_D_COEF, 16'h8001);
    write_reg(CFG_KD_DT, 32'h0002_0000);
    write_reg(CFG_OUT_MIN, 32'hFF9C_0000);
    write_reg(CFG_OUT_MAX, 32'h0064_0000);
    write_reg(CFG_INT_BNDS, {32'h000A_0000, 32'hFFF6_0000});
    push_item(OP_VEL, 32'h0005_0000, '0, '0);
    push_item(OP_POS, 32'h0007_0000, '0, '0);
    push_item(OP_VEL, 32'h0002_0000, '0, Q_ONE);
    push_item(OP_VEL, '0, 32'h0003_0000, '0);
    push_item(OP_POS, 32'h00C8_0000, '0, '0);
    push_item(OP_POS, '0, 32'h00C8_0000, '0);
    push_item(OP_CLR, '0, '0, '0);
    push_item(OP_NOP, Q_ONE, '0, Q_ONE);
    push_item(OP_POS, Q_ONE, '0, '0);
  endtask

  task automatic test_random_traffic();
    logic [31:0] g[4];
    logic [15:0] dc;
    logic [31:0] lo, hi, ilo, ihi;
    logic [31:0] sp;
    logic [31:0] ms;
    for (int ph = 0; ph < PHASES; ph++) begin
      settle();
      calm = (ph % 4 == 3);
      if (ph == 0) begin
        foreach (g[k]) g[k] = W_MAX;
        dc = COEF_ONE;
        lo = W_MIN;
        hi = W_MAX;
        ilo = W_MIN;
        ihi = W_MAX;
      end else if (ph == 1) begin
        foreach (g[k]) g[k] = W_MIN;
        dc = '0;
        lo = W_MAX;
        hi = W_MIN;
        ilo = W_MAX;
        ihi = W_MIN;
      end else begin
        foreach (g[k]) g[k] = rand_gain();
        dc = rand_coef();
        rand_limits(lo, hi);
        rand_limits(ilo, ihi);
      end
      write_reg(CFG_KP, g[0]);
      write_reg(CFG_KI_DT, g[1]);
      write_reg(CFG_KD_DT, g[2]);
      write_reg(CFG_FF, g[3]);
      write_reg(CFG_D_COEF, dc);
      write_reg(CFG_OUT_MIN, lo);
      write_reg(CFG_OUT_MAX, hi);
      write_reg(CFG_INT_BNDS, {ihi, ilo});
      sp = rand_word();
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (i == PHASE_ITEMS / 2 && ph % 3 == 1) drain_results();
        if ($urandom_range(0, 19) == 0) sp = rand_word();
        // mostly a loop tracking its setpoint, sometimes a wild measurement
        if ($urandom_range(0, 4) == 0)
          ms = rand_word();
        else
          ms = sp + ($urandom_range(0, 32'h0014_0000) - 32'h000A_0000);
        push_item(rand_opcode(), sp, ms, rand_word());
      end
    end
    calm = 1'b0;
  endtask

  initial begin
    err_count         = 0;
    idle_cycles       = 0;
    rdy_left          = 0;
    calm              = 1'b0;
    rst               = 1'b1;
    cfg_we            = 1'b0;
    cfg_idx           = '0;
    cfg_data          = '0;
    in_ch.valid       = 1'b0;
    in_ch.opcode      = '0;
    in_ch.setpoint    = '0;
    in_ch.measured    = '0;
    in_ch.feedforward = '0;
    out_ch.ready      = 1'b0;
    reset_image();
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_defaults();
    test_special_cases();
    test_random_traffic();

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (err_count == 0)
      $display("pid_velocity_positional regression: pass");
    else
      $display("pid_velocity_positional regression: fail");
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/core/pvp_pkg.sv
rtl/core/pvp_if.sv
rtl/core/pvp_mac.sv
rtl/core/pid_velocity_positional.sv
rtl/core/pvp_chk.sv
verif/tb_pid_velocity_positional.sv
